/* rtl/graph_table_with_dfs_assert.svh */
// ----------------------------------------------------------------------------
// Graph table assertion macros
// Concurrent property shorthands clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GRAPH_TABLE_WITH_DFS_ASSERT_SVH
`define GRAPH_TABLE_WITH_DFS_ASSERT_SVH

// Same-cycle implication.
`define GTDFS_ASSERT_IMP(name, cond, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication.
`define GTDFS_ASSERT_NXT(name, cond, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* rtl/gtdfs_pkg.sv */
// ----------------------------------------------------------------------------
// Graph table package
// Operation codes, status codes and default sizes of the graph engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gtdfs_pkg;

    typedef logic [2:0] t_func;
    typedef logic [2:0] t_status;

    localparam t_func FN_ADDV  = 3'd0;
    localparam t_func FN_DELV  = 3'd1;
    localparam t_func FN_ADDE  = 3'd2;
    localparam t_func FN_DELE  = 3'd3;
    localparam t_func FN_NBRS  = 3'd4;
    localparam t_func FN_EMPTY = 3'd5;
    localparam t_func FN_DFS   = 3'd6;

    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_EXISTS     = 3'd1;
    localparam t_status ST_NO_VERTEX  = 3'd2;
    localparam t_status ST_NO_EDGE    = 3'd3;
    localparam t_status ST_TABLE_FULL = 3'd4;
    localparam t_status ST_LIST_FULL  = 3'd5;

    localparam int P_MAX_VERTICES = 16;
    localparam int P_MAX_DEGREE   = 16;

endpackage

`default_nettype wire

/* rtl/gtdfs_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gtdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/graph_table_with_dfs.sv */
// A key lookup scans the slots in order, edge list sweeps and neighbour listing step through
// each edge, and dfs takes each vertex and edge in turn; the RAMs have registered reads, so
// a read state always comes before the state that uses the data.
// One item is worked on at a time; o_stall stays high until its last word is loaded.
// Reset (synchronous, active low) empties the table, edge counts and visited marks;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
// Graph table with depth-first search
// Keyed vertex table with ordered adjacency lists, edge edits, neighbour
// listing and an iterative depth-first walk driven by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_table_with_dfs #(
    parameter int MAX_VERTICES = gtdfs_pkg::P_MAX_VERTICES,
    parameter int MAX_DEGREE   = gtdfs_pkg::P_MAX_DEGREE
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire gtdfs_pkg::t_func   i_func,
    input  wire logic signed [31:0] i_key_a,
    input  wire logic signed [31:0] i_key_b,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output gtdfs_pkg::t_status      o_status,
    output logic signed [31:0]      o_vertex_out,
    output logic                    o_has_vertex,
    output logic                    o_last,
    output logic                    o_graph_empty
);

    import gtdfs_pkg::*;
    `include "graph_table_with_dfs_assert.svh"

    localparam int NV  = MAX_VERTICES;
    localparam int MD  = MAX_DEGREE;
    localparam int VW  = $clog2(NV);
    localparam int SCW = $clog2(NV + 1);
    localparam int CW  = $clog2(MD + 1);
    localparam int AD  = NV * MD;
    localparam int AW  = $clog2(AD);
    localparam int SD  = AD + 1;
    localparam int SAW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_FRD  = 5'd1;
    localparam logic [4:0] S_FCMP = 5'd2;
    localparam logic [4:0] S_DISP = 5'd3;
    localparam logic [4:0] S_RNXT = 5'd4;
    localparam logic [4:0] S_DRD  = 5'd5;
    localparam logic [4:0] S_DCMP = 5'd6;
    localparam logic [4:0] S_NRD  = 5'd7;
    localparam logic [4:0] S_NKW  = 5'd8;
    localparam logic [4:0] S_NKEY = 5'd9;
    localparam logic [4:0] S_POP  = 5'd10;
    localparam logic [4:0] S_PCHK = 5'd11;
    localparam logic [4:0] S_PKEY = 5'd12;
    localparam logic [4:0] S_ERD  = 5'd13;
    localparam logic [4:0] S_ECHK = 5'd14;
    localparam logic [4:0] S_EMIT = 5'd15;
    localparam logic [4:0] S_FIN  = 5'd16;

    logic [4:0]        r_state;
    logic [4:0]        r_ret;
    t_func             r_func;
    logic [31:0]       r_ka;
    logic [31:0]       r_kb;
    t_status           r_st;
    logic              r_sb;
    logic [VW-1:0]     r_i;
    logic              r_fa;
    logic              r_fb;
    logic [VW-1:0]     r_ai;
    logic [VW-1:0]     r_bi;
    logic [SCW-1:0]    r_s;
    logic [CW-1:0]     r_r;
    logic [CW-1:0]     r_w;
    logic              r_hit;
    logic [VW-1:0]     r_cur;
    logic [SPW-1:0]    r_sp;
    logic [31:0]       r_nkey;
    logic [31:0]       r_pkey;
    logic              r_pv;
    logic [NV-1:0]     r_used;
    logic [NV-1:0]     r_visited;
    logic [CW-1:0]     r_count [NV];

    logic              r_ov;
    t_status           r_ostat;
    logic [31:0]       r_okey;
    logic              r_ohas;
    logic              r_olast;
    logic              r_oempty;

    logic              w_out_free;
    logic              w_ld;
    logic [VW-1:0]     w_free_idx;
    logic              w_free_ok;
    logic [VW-1:0]     w_ds;
    logic [VW-1:0]     w_dt;
    logic              w_all;
    logic [31:0]       w_key;

    logic              key_we;
    logic [VW-1:0]     key_waddr;
    logic [VW-1:0]     key_raddr;
    logic [31:0]       key_rdata;
    logic              adj_we;
    logic [AW-1:0]     adj_waddr;
    logic [VW-1:0]     adj_wdata;
    logic [AW-1:0]     adj_raddr;
    logic [VW-1:0]     adj_rdata;
    logic              stk_we;
    logic [SAW-1:0]    stk_waddr;
    logic [VW-1:0]     stk_wdata;
    logic [SAW-1:0]    stk_raddr;
    logic [VW-1:0]     stk_rdata;

    function automatic logic [AW-1:0] f_adj(input logic [VW-1:0] s, input logic [CW-1:0] k);
        return AW'(AW'(s) * AW'(MD)) + AW'(k);
    endfunction

    assign w_out_free = !r_ov || !i_stall;
    assign w_ld  = w_out_free && ((r_state == S_FIN) || ((r_state == S_EMIT) && r_pv));
    assign w_ds  = (r_func == FN_DELV) ? r_s[VW-1:0] : r_ai;
    assign w_dt  = (r_func == FN_DELV) ? r_ai : r_bi;
    assign w_all = (r_func == FN_DELV);
    assign w_key = r_sb ? r_kb : r_ka;

    // Lowest free slot.
    always_comb begin
        w_free_idx = '0;
        w_free_ok  = 1'b0;
        for (int k = NV - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                w_free_idx = VW'(k);
                w_free_ok  = 1'b1;
            end
        end
    end

    always_comb begin
        key_we    = 1'b0;
        key_waddr = w_free_idx;
        key_raddr = r_i;
        adj_we    = 1'b0;
        adj_waddr = f_adj(w_ds, r_w);
        adj_wdata = adj_rdata;
        adj_raddr = f_adj(w_ds, r_r);
        stk_we    = 1'b0;
        stk_waddr = r_sp[SAW-1:0];
        stk_wdata = adj_rdata;
        stk_raddr = SAW'(r_sp - SPW'(1));
        unique case (r_state)
            S_DISP: begin
                if (r_func == FN_ADDV) begin
                    key_we = !r_fa && w_free_ok;
                end
                if (r_func == FN_ADDE) begin
                    adj_we    = r_sb && r_fa && r_fb && (r_count[r_ai] < CW'(MD));
                    adj_waddr = f_adj(r_ai, r_count[r_ai]);
                    adj_wdata = r_bi;
                end
                if (r_func == FN_DFS) begin
                    stk_we    = r_fa;
                    stk_waddr = '0;
                    stk_wdata = r_ai;
                end
            end
            S_DCMP: begin
                adj_we = !((adj_rdata == w_dt) && (w_all || !r_hit));
            end
            S_NRD:  adj_raddr = f_adj(r_ai, r_r);
            S_NKW:  key_raddr = adj_rdata;
            S_PCHK: key_raddr = stk_rdata;
            S_ERD:  adj_raddr = f_adj(r_cur, r_r);
            S_ECHK: stk_we = !r_visited[adj_rdata] && (r_sp < SPW'(SD));
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ov      <= 1'b0;
            r_pv      <= 1'b0;
            r_used    <= '0;
            r_visited <= '0;
            r_count   <= '{default: '0};
            r_sp      <= '0;
        end else begin
            if (w_ld) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func  <= i_func;
                        r_ka    <= i_key_a;
                        r_kb    <= i_key_b;
                        r_st    <= ST_OK;
                        r_sb    <= 1'b0;
                        r_i     <= '0;
                        r_pv    <= 1'b0;
                        r_state <= S_FRD;
                    end
                end
                S_FRD: r_state <= S_FCMP;
                S_FCMP: begin
                    if ((r_used[r_i] && key_rdata == w_key) || r_i == VW'(NV - 1)) begin
                        if (!r_sb) begin
                            r_fa <= r_used[r_i] && key_rdata == w_key;
                            r_ai <= r_i;
                        end else begin
                            r_fb <= r_used[r_i] && key_rdata == w_key;
                            r_bi <= r_i;
                        end
                        r_state <= S_DISP;
                    end else begin
                        r_i     <= r_i + VW'(1);
                        r_state <= S_FRD;
                    end
                end
                S_DISP: begin
                    unique case (r_func)
                        FN_ADDV: begin
                            if (r_fa) begin
                                r_st <= ST_EXISTS;
                            end else if (!w_free_ok) begin
                                r_st <= ST_TABLE_FULL;
                            end else begin
                                r_used[w_free_idx]    <= 1'b1;
                                r_count[w_free_idx]   <= '0;
                                r_visited[w_free_idx] <= 1'b0;
                            end
                            r_state <= S_FIN;
                        end
                        FN_DELV: begin
                            if (!r_fa) begin
                                r_st    <= ST_NO_VERTEX;
                                r_state <= S_FIN;
                            end else begin
                                r_s     <= '0;
                                r_state <= S_RNXT;
                            end
                        end
                        FN_ADDE, FN_DELE: begin
                            if (!r_sb && (r_fa || r_func == FN_ADDE)) begin
                                r_sb    <= 1'b1;
                                r_i     <= '0;
                                r_state <= S_FRD;
                            end else if (!r_fa) begin
                                r_st    <= ST_NO_VERTEX;
                                r_state <= S_FIN;
                            end else if (r_func == FN_ADDE) begin
                                if (!r_fb) begin
                                    r_st <= ST_NO_VERTEX;
                                end else if (r_count[r_ai] >= CW'(MD)) begin
                                    r_st <= ST_LIST_FULL;
                                end else begin
                                    r_count[r_ai] <= r_count[r_ai] + CW'(1);
                                end
                                r_state <= S_FIN;
                            end else if (!r_fb) begin
                                r_st    <= ST_NO_EDGE;
                                r_state <= S_FIN;
                            end else begin
                                r_r     <= '0;
                                r_w     <= '0;
                                r_hit   <= 1'b0;
                                r_state <= S_DRD;
                            end
                        end
                        FN_NBRS: begin
                            if (!r_fa) begin
                                r_st    <= ST_NO_VERTEX;
                                r_state <= S_FIN;
                            end else begin
                                r_r     <= '0;
                                r_state <= S_NRD;
                            end
                        end
                        FN_DFS: begin
                            if (!r_fa) begin
                                r_st    <= ST_NO_VERTEX;
                                r_state <= S_FIN;
                            end else begin
                                r_sp    <= SPW'(1);
                                r_state <= S_POP;
                            end
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_RNXT: begin
                    if (r_s == SCW'(NV)) begin
                        r_used[r_ai]    <= 1'b0;
                        r_count[r_ai]   <= '0;
                        r_visited[r_ai] <= 1'b0;
                        r_state         <= S_FIN;
                    end else if (r_used[r_s[VW-1:0]]) begin
                        r_r     <= '0;
                        r_w     <= '0;
                        r_hit   <= 1'b0;
                        r_state <= S_DRD;
                    end else begin
                        r_s <= r_s + SCW'(1);
                    end
                end
                S_DRD: begin
                    if (r_r == r_count[w_ds]) begin
                        r_count[w_ds] <= r_w;
                        if (r_func == FN_DELV) begin
                            r_s     <= r_s + SCW'(1);
                            r_state <= S_RNXT;
                        end else begin
                            r_st    <= r_hit ? ST_OK : ST_NO_EDGE;
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_state <= S_DCMP;
                    end
                end
                S_DCMP: begin
                    // First match skipped (every one for vertex delete); rest slide down.
                    if ((adj_rdata == w_dt) && (w_all || !r_hit)) begin
                        r_hit <= 1'b1;
                    end else begin
                        r_w <= r_w + CW'(1);
                    end
                    r_r     <= r_r + CW'(1);
                    r_state <= S_DRD;
                end
                S_NRD: begin
                    r_state <= (r_r == r_count[r_ai]) ? S_FIN : S_NKW;
                end
                S_NKW: r_state <= S_NKEY;
                S_NKEY: begin
                    r_nkey  <= key_rdata;
                    r_r     <= r_r + CW'(1);
                    r_ret   <= S_NRD;
                    r_state <= S_EMIT;
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_sp    <= r_sp - SPW'(1);
                        r_state <= S_PCHK;
                    end
                end
                S_PCHK: begin
                    r_cur <= stk_rdata;
                    if (r_visited[stk_rdata]) begin
                        r_state <= S_POP;
                    end else begin
                        r_visited[stk_rdata] <= 1'b1;
                        r_state              <= S_PKEY;
                    end
                end
                S_PKEY: begin
                    r_nkey  <= key_rdata;
                    r_r     <= '0;
                    r_ret   <= S_ERD;
                    r_state <= S_EMIT;
                end
                S_ERD: begin
                    r_state <= (r_r == r_count[r_cur]) ? S_POP : S_ECHK;
                end
                S_ECHK: begin
                    if (stk_we) begin
                        r_sp <= r_sp + SPW'(1);
                    end
                    r_r     <= r_r + CW'(1);
                    r_state <= S_ERD;
                end
                S_EMIT: begin
                    // A key is held back one word so the final one can carry last.
                    if (!r_pv || w_out_free) begin
                        if (r_pv) begin
                            r_ostat  <= ST_OK;
                            r_okey   <= r_pkey;
                            r_ohas   <= 1'b1;
                            r_olast  <= 1'b0;
                            r_oempty <= ~|r_used;
                        end
                        r_pkey  <= r_nkey;
                        r_pv    <= 1'b1;
                        r_state <= r_ret;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_ostat  <= r_pv ? ST_OK : r_st;
                        r_okey   <= r_pv ? r_pkey : 32'd0;
                        r_ohas   <= r_pv;
                        r_olast  <= 1'b1;
                        r_oempty <= ~|r_used;
                        r_pv      <= 1'b0;
                        r_visited <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    gtdfs_ram #(.WIDTH(32), .DEPTH(NV)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_ka),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    gtdfs_ram #(.WIDTH(VW), .DEPTH(AD)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    gtdfs_ram #(.WIDTH(VW), .DEPTH(SD)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ov;
    assign o_status      = r_ostat;
    assign o_vertex_out  = r_okey;
    assign o_has_vertex  = r_ohas;
    assign o_last        = r_olast;
    assign o_graph_empty = r_oempty;

    `GTDFS_ASSERT_NXT(a_busy_after_accept, i_valid && !o_stall, o_stall,
        "accepted word did not make the block busy")
    `GTDFS_ASSERT_IMP(a_bare_result_last, o_valid && !o_has_vertex,
        o_last && o_vertex_out == 32'd0, "result without key is not a final zero word")
    `GTDFS_ASSERT_IMP(a_key_status_ok, o_valid && o_has_vertex, o_status == ST_OK,
        "key word with non-ok status")
    `GTDFS_ASSERT_IMP(a_idle_marks_clear, r_state == S_IDLE, r_visited == '0,
        "visited marks left set between operations")

endmodule

`default_nettype wire
